>>> rtl/core/fnp_pkg.sv
// ----------------------------------------------------------------------------
// fnp_pkg
// Types and constants shared by the FASTA nucleotide packer modules.
// ----------------------------------------------------------------------------
package fnp_pkg;

  // Operations handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_BASE,
    OP_HEADER,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] code;
  } op_t;

  // Back end sequencing for header and end-of-input operations.
  typedef enum logic [1:0] {
    PH_FLUSH,
    PH_RECORD,
    PH_TOTALS
  } phase_t;

  // Result kinds.
  localparam logic [1:0] RES_PACKED   = 2'd0;
  localparam logic [1:0] RES_SEQUENCE = 2'd1;
  localparam logic [1:0] RES_TOTALS   = 2'd2;

  // Request types.
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_LAST = 8'h7F;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  localparam int HDR_CNT_W = 32;
  localparam int OPQ_DEPTH = 4;

  // Two-bit code of a base letter; anything unknown packs as A.
  function automatic logic [1:0] base_code(input logic [7:0] b);
    logic [7:0] u;
    u = b & CASE_MASK;
    case (u)
      CHAR_G:  base_code = 2'd1;
      CHAR_T:  base_code = 2'd2;
      CHAR_C:  base_code = 2'd3;
      default: base_code = 2'd0;
    endcase
  endfunction

  // Place a base into its slot; slot 0 lands in bits 7:6.
  function automatic logic [7:0] slot_bits(input logic [1:0] code, input logic [1:0] slot);
    slot_bits = {6'd0, code} << {~slot, 1'b0};
  endfunction

endpackage

>>> rtl/core/fnp_front.sv
// ----------------------------------------------------------------------------
// fnp_front
// Accepts FASTA bytes, tracks header text and classifies each byte.
// ----------------------------------------------------------------------------
module fnp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            in_req_type,
  input  logic [7:0]      in_byte,
  output logic            op_valid,
  output fnp_pkg::op_t    op
);

  logic in_header_r;
  logic in_header_nxt;

  always_comb begin
    op_valid      = 1'b0;
    op.kind       = fnp_pkg::OP_BASE;
    op.code       = fnp_pkg::base_code(in_byte);
    in_header_nxt = in_header_r;
    if (accept) begin
      if (in_req_type == fnp_pkg::REQ_END) begin
        op_valid      = 1'b1;
        op.kind       = fnp_pkg::OP_END;
        in_header_nxt = 1'b0;
      end else if (in_header_r) begin
        if (in_byte == fnp_pkg::CHAR_LF) begin
          in_header_nxt = 1'b0;
        end
      end else if (in_byte == fnp_pkg::CHAR_GT) begin
        op_valid      = 1'b1;
        op.kind       = fnp_pkg::OP_HEADER;
        in_header_nxt = 1'b1;
      end else if (in_byte inside {[fnp_pkg::CHAR_A:fnp_pkg::CHAR_LAST]}) begin
        op_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r <= 1'b0;
    end else begin
      in_header_r <= in_header_nxt;
    end
  end

endmodule

>>> rtl/core/fnp_op_queue.sv
// ----------------------------------------------------------------------------
// fnp_op_queue
// Small queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module fnp_op_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fnp_pkg::op_t    wr_op,
  input  logic            rd_en,
  output fnp_pkg::op_t    rd_op,
  output logic            q_empty,
  output logic            q_full
);

  localparam int PW = $clog2(fnp_pkg::OPQ_DEPTH);
  localparam int CW = $clog2(fnp_pkg::OPQ_DEPTH + 1);

  fnp_pkg::op_t mem [fnp_pkg::OPQ_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign q_empty = (count_r == CW'(0));
  assign q_full  = (count_r == CW'(fnp_pkg::OPQ_DEPTH));
  assign rd_op   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? PW'(wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? PW'(rd_ptr_r + PW'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = CW'(count_r + CW'(1));
    end else if (!wr_en && rd_en) begin
      count_nxt = CW'(count_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/fnp_back.sv
// ----------------------------------------------------------------------------
// fnp_back
// Packs bases, keeps the sequence counters and drives the result register.
// ----------------------------------------------------------------------------
module fnp_back #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           op_valid,
  input  fnp_pkg::op_t                   op,
  output logic                           op_consume,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_packed_byte,
  output logic [COUNT_WIDTH-1:0]         out_byte_count,
  output logic [COUNT_WIDTH-1:0]         out_base_position,
  output logic [fnp_pkg::HDR_CNT_W-1:0]  out_sequence_total,
  output logic                           out_last_result
);

  localparam int HW = fnp_pkg::HDR_CNT_W;

  fnp_pkg::phase_t        phase_r, phase_nxt;
  logic [7:0]             acc_r, acc_nxt;
  logic [1:0]             slot_r, slot_nxt;
  logic [COUNT_WIDTH-1:0] seq_bytes_r, seq_bytes_nxt;
  logic [COUNT_WIDTH-1:0] seq_bases_r, seq_bases_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [HW-1:0]          hdr_cnt_r, hdr_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             kind_r;
  logic [7:0]             packed_r;
  logic [COUNT_WIDTH-1:0] bcount_r;
  logic [COUNT_WIDTH-1:0] bpos_r;
  logic [HW-1:0]          stotal_r;
  logic                   last_r;

  logic                   out_ready;
  logic                   emit;
  logic [1:0]             e_kind;
  logic [7:0]             e_packed;
  logic [COUNT_WIDTH-1:0] e_bcount;
  logic [COUNT_WIDTH-1:0] e_bpos;
  logic [HW-1:0]          e_stotal;
  logic                   e_last;
  logic [7:0]             acc_new;
  logic [COUNT_WIDTH-1:0] total_sum;

  assign out_ready = !out_valid_r || pop;
  assign acc_new   = acc_r | fnp_pkg::slot_bits(op.code, slot_r);
  assign total_sum = COUNT_WIDTH'(total_r + seq_bases_r);

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    slot_nxt      = slot_r;
    seq_bytes_nxt = seq_bytes_r;
    seq_bases_nxt = seq_bases_r;
    total_nxt     = total_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    op_consume    = 1'b0;
    emit          = 1'b0;
    e_kind        = fnp_pkg::RES_PACKED;
    e_packed      = '0;
    e_bcount      = '0;
    e_bpos        = '0;
    e_stotal      = '0;
    e_last        = 1'b0;
    if (op_valid && out_ready) begin
      case (op.kind)
        fnp_pkg::OP_BASE: begin
          op_consume    = 1'b1;
          seq_bases_nxt = COUNT_WIDTH'(seq_bases_r + COUNT_WIDTH'(1));
          if (slot_r == 2'd3) begin
            emit          = 1'b1;
            e_packed      = acc_new;
            e_last        = 1'b1;
            acc_nxt       = '0;
            slot_nxt      = 2'd0;
            seq_bytes_nxt = COUNT_WIDTH'(seq_bytes_r + COUNT_WIDTH'(1));
          end else begin
            acc_nxt  = acc_new;
            slot_nxt = 2'(slot_r + 2'd1);
          end
        end
        fnp_pkg::OP_HEADER, fnp_pkg::OP_END: begin
          case (phase_r)
            fnp_pkg::PH_FLUSH: begin
              if (slot_r != 2'd0) begin
                emit          = 1'b1;
                e_packed      = acc_r;
                acc_nxt       = '0;
                slot_nxt      = 2'd0;
                seq_bytes_nxt = COUNT_WIDTH'(seq_bytes_r + COUNT_WIDTH'(1));
              end
              phase_nxt = fnp_pkg::PH_RECORD;
            end
            fnp_pkg::PH_RECORD: begin
              emit          = 1'b1;
              e_kind        = fnp_pkg::RES_SEQUENCE;
              e_bcount      = seq_bytes_r;
              e_bpos        = total_sum;
              total_nxt     = total_sum;
              seq_bytes_nxt = '0;
              seq_bases_nxt = '0;
              if (op.kind == fnp_pkg::OP_HEADER) begin
                e_last      = 1'b1;
                hdr_cnt_nxt = HW'(hdr_cnt_r + HW'(1));
                op_consume  = 1'b1;
                phase_nxt   = fnp_pkg::PH_FLUSH;
              end else begin
                phase_nxt = fnp_pkg::PH_TOTALS;
              end
            end
            fnp_pkg::PH_TOTALS: begin
              emit          = 1'b1;
              e_kind        = fnp_pkg::RES_TOTALS;
              e_bpos        = total_r;
              e_stotal      = hdr_cnt_r;
              e_last        = 1'b1;
              acc_nxt       = '0;
              slot_nxt      = 2'd0;
              seq_bytes_nxt = '0;
              seq_bases_nxt = '0;
              total_nxt     = '0;
              hdr_cnt_nxt   = '0;
              op_consume    = 1'b1;
              phase_nxt     = fnp_pkg::PH_FLUSH;
            end
            default: begin
              phase_nxt = fnp_pkg::PH_FLUSH;
            end
          endcase
        end
        default: begin
          op_consume = 1'b1;
        end
      endcase
    end
    out_valid_nxt = emit ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fnp_pkg::PH_FLUSH;
      acc_r       <= '0;
      slot_r      <= '0;
      seq_bytes_r <= '0;
      seq_bases_r <= '0;
      total_r     <= '0;
      hdr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      slot_r      <= slot_nxt;
      seq_bytes_r <= seq_bytes_nxt;
      seq_bases_r <= seq_bases_nxt;
      total_r     <= total_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= e_kind;
      packed_r <= e_packed;
      bcount_r <= e_bcount;
      bpos_r   <= e_bpos;
      stotal_r <= e_stotal;
      last_r   <= e_last;
    end
  end

  assign empty              = !out_valid_r;
  assign out_kind           = kind_r;
  assign out_packed_byte    = packed_r;
  assign out_byte_count     = bcount_r;
  assign out_base_position  = bpos_r;
  assign out_sequence_total = stotal_r;
  assign out_last_result    = last_r;

  // An end-of-input operation leaves every counter at its reset value.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (op_consume && op.kind == fnp_pkg::OP_END) |=>
      (slot_r == 2'd0 && seq_bases_r == '0 && total_r == '0 && hdr_cnt_r == '0))
    else $error("end of input did not clear the counters");

  // A phase other than flush only runs while its header or end operation is held.
  a_phase_op: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != fnp_pkg::PH_FLUSH) |->
      (op_valid && (op.kind == fnp_pkg::OP_HEADER || op.kind == fnp_pkg::OP_END)))
    else $error("sequencer phase without a pending header or end operation");

  // A base only completes a packed byte from the last slot.
  a_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && op.kind == fnp_pkg::OP_BASE) |-> (slot_r == 2'd3))
    else $error("packed byte emitted before four bases");

  // A new result is never loaded over one that was not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r) |-> pop)
    else $error("result register overwritten");

endmodule

>>> rtl/core/fasta_nucleotide_packer.sv
// ----------------------------------------------------------------------------
// fasta_nucleotide_packer
// Data path: a base that completes a packed byte is queued at its push
// transaction and then loaded from the queue head into the result register,
// from which it can be popped. Input: one byte per cycle while the queue is
// not full; the back end steps a header through its flush and record phases
// and end of input through its flush, record and totals phases.
// Reset: synchronous, active low; clears all counters, the queue and results.
// ----------------------------------------------------------------------------
//
// The front end classifies each incoming byte. Header text (from '>' up to
// and including the newline) and bytes outside the base range ('A' up to 0x7F)
// are dropped right there, so only three kinds of operation reach the
// queue: a base with its two-bit code, a header start and end of input.
//
// The back end takes one operation from the queue per cycle while the result
// register can take a new result. A base shifts its code into the accumulator
// and emits a packed byte on its fourth slot. A header start flushes any
// partial byte and then emits the sequence record. End of input does the same
// and then emits the file totals record before all counters return to zero.
// Because header and end operations wait at the queue head while the back end
// sequences them, the front end keeps accepting bytes until the queue fills.
//
// The result register is loaded whenever it is empty or its current result is
// taken by a pop transaction in the same cycle, so results stream at full rate.
// ----------------------------------------------------------------------------
module fasta_nucleotide_packer #(
  parameter int COUNT_WIDTH = 40
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           push,
  output logic                           full,
  input  logic                           in_req_type,
  input  logic [7:0]                     in_byte,
  // Result channel.
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_packed_byte,
  output logic [COUNT_WIDTH-1:0]         out_byte_count,
  output logic [COUNT_WIDTH-1:0]         out_base_position,
  output logic [fnp_pkg::HDR_CNT_W-1:0]  out_sequence_total,
  output logic                           out_last_result
);

  logic          accept;
  logic          fe_valid;
  fnp_pkg::op_t  fe_op;
  fnp_pkg::op_t  head_op;
  logic          q_empty;
  logic          q_full;
  logic          consume;

  // A push transaction completes whenever the queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  fnp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_req_type (in_req_type),
    .in_byte     (in_byte),
    .op_valid    (fe_valid),
    .op          (fe_op)
  );

  fnp_op_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_valid),
    .wr_op   (fe_op),
    .rd_en   (consume),
    .rd_op   (head_op),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  fnp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .op_valid           (!q_empty),
    .op                 (head_op),
    .op_consume         (consume),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_packed_byte    (out_packed_byte),
    .out_byte_count     (out_byte_count),
    .out_base_position  (out_base_position),
    .out_sequence_total (out_sequence_total),
    .out_last_result    (out_last_result)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the FASTA nucleotide packer. A directed table
// covers the base codes, ignored bytes, header handling and end of input. A
// random part follows that streams well-formed FASTA records mixed with noise
// and broken headers. Every result is checked against a behavioral predictor
// while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW             = 40;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 340;
  localparam int HOLD_CYCLES    = 200;
  localparam int BURST_BASES    = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int N_DIRECTED     = 26;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic [1:0]                    kind;
    logic [7:0]                    packed_byte;
    logic [CW-1:0]                 byte_count;
    logic [CW-1:0]                 base_position;
    logic [fnp_pkg::HDR_CNT_W-1:0] sequence_total;
    logic                          last_result;
  } result_t;

  // One row of the directed table. Where check is set, the last result that
  // the row causes is typed in next to it.
  typedef struct packed {
    logic                          req;
    logic [7:0]                    data;
    logic                          check;
    logic [1:0]                    kind;
    logic [7:0]                    packed_byte;
    logic [CW-1:0]                 byte_count;
    logic [CW-1:0]                 base_position;
    logic [fnp_pkg::HDR_CNT_W-1:0] sequence_total;
  } stim_row_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          push        = 1'b0;
  logic                          in_req_type = 1'b0;
  logic [7:0]                    in_byte     = 8'h00;
  logic                          pop         = 1'b0;
  logic                          full;
  logic                          empty;
  logic [1:0]                    out_kind;
  logic [7:0]                    out_packed_byte;
  logic [CW-1:0]                 out_byte_count;
  logic [CW-1:0]                 out_base_position;
  logic [fnp_pkg::HDR_CNT_W-1:0] out_sequence_total;
  logic                          out_last_result;

  fasta_nucleotide_packer #(
    .COUNT_WIDTH(CW)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_req_type        (in_req_type),
    .in_byte            (in_byte),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_packed_byte    (out_packed_byte),
    .out_byte_count     (out_byte_count),
    .out_base_position  (out_base_position),
    .out_sequence_total (out_sequence_total),
    .out_last_result    (out_last_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results still owed by the block, oldest first.
  result_t expected_results[$];
  int      error_count = 0;

  // Number of bytes accepted by the block in the current part of the run.
  int      sent_items = 0;

  // Idle control shared between the two sides. The quiet flags turn idling
  // off for a stretch; hold_req asks the receiver for one long stall.
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  bit      hold_req = 1'b0;

  // Predictor state, mirroring what the block holds between bytes.
  logic [7:0]                    fp_acc;
  logic [1:0]                    fp_slot;
  logic                          fp_in_hdr;
  logic [CW-1:0]                 fp_seq_bytes;
  logic [CW-1:0]                 fp_seq_bases;
  logic [CW-1:0]                 fp_total_bases;
  logic [fnp_pkg::HDR_CNT_W-1:0] fp_hdr_count;

  logic [7:0] base_alphabet [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

  // The directed stream. The first four bytes give one packed byte with all
  // four codes and both letter cases. DEL counts as a base that packs as A,
  // while 0x80, 0xFF, '@' and NUL are dropped. A header opened with a partial
  // byte pending forces a flush; a '>' and a letter inside the header are
  // header text. End of input then flushes, closes the sequence and reports
  // totals. Further rows cover end of input straight after an earlier one, a header
  // at the very start, and a header cut off by end of input.
  stim_row_t directed_rows [N_DIRECTED] = '{
    //  req               data   check kind                  pb     bc  bp  st
    '{fnp_pkg::REQ_DATA, "A",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "c",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "G",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "t",   1'b1, fnp_pkg::RES_PACKED,   8'h36, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'h7F, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'h80, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'hFF, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "@",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'h00, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "Z",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "C",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, ">",   1'b1, fnp_pkg::RES_SEQUENCE, 8'h00, 2,  7,  0},
    '{fnp_pkg::REQ_DATA, ">",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "A",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'h0A, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "g",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, 8'h0A, 1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_END,  8'hFF, 1'b1, fnp_pkg::RES_TOTALS,   8'h00, 0,  8,  1},
    '{fnp_pkg::REQ_END,  8'h00, 1'b1, fnp_pkg::RES_TOTALS,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, ">",   1'b1, fnp_pkg::RES_SEQUENCE, 8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "T",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_END,  "A",   1'b1, fnp_pkg::RES_TOTALS,   8'h00, 0,  0,  1},
    '{fnp_pkg::REQ_DATA, "C",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "C",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "C",   1'b0, fnp_pkg::RES_PACKED,   8'h00, 0,  0,  0},
    '{fnp_pkg::REQ_DATA, "C",   1'b1, fnp_pkg::RES_PACKED,   8'hFF, 0,  0,  0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] pb,
                                          logic [CW-1:0] bc, logic [CW-1:0] bp,
                                          logic [fnp_pkg::HDR_CNT_W-1:0] st);
    result_t r;
    r.kind           = kind;
    r.packed_byte    = pb;
    r.byte_count     = bc;
    r.base_position  = bp;
    r.sequence_total = st;
    r.last_result    = 1'b0;
    return r;
  endfunction

  function automatic void clear_packer_state();
    fp_acc         = '0;
    fp_slot        = '0;
    fp_in_hdr      = 1'b0;
    fp_seq_bytes   = '0;
    fp_seq_bases   = '0;
    fp_total_bases = '0;
    fp_hdr_count   = '0;
  endfunction

  // A partial byte goes out with its unused low slots left at zero.
  function automatic void flush_partial_byte();
    if (fp_slot != 2'd0) begin
      expected_results.push_back(make_result(fnp_pkg::RES_PACKED, fp_acc, '0, '0, '0));
      fp_acc       = '0;
      fp_slot      = '0;
      fp_seq_bytes = fp_seq_bytes + 1'b1;
    end
  endfunction

  // The sequence record carries the position where the next sequence starts.
  function automatic void close_sequence_record();
    fp_total_bases = fp_total_bases + fp_seq_bases;
    expected_results.push_back(make_result(fnp_pkg::RES_SEQUENCE, 8'h00, fp_seq_bytes,
                                           fp_total_bases, '0));
    fp_seq_bytes = '0;
    fp_seq_bases = '0;
  endfunction

  // Works out what one accepted byte causes, queues it, and hands back the
  // last of those results with the number of results.
  function automatic void predict_packing(input logic req, input logic [7:0] b,
                                          output result_t last_out, output int n_out);
    int         size_before;
    logic [7:0] upper;
    logic [1:0] code;
    size_before = expected_results.size();
    last_out    = '0;
    if (req == fnp_pkg::REQ_END) begin
      flush_partial_byte();
      close_sequence_record();
      expected_results.push_back(make_result(fnp_pkg::RES_TOTALS, 8'h00, '0,
                                             fp_total_bases, fp_hdr_count));
      clear_packer_state();
    end else if (fp_in_hdr) begin
      // Everything up to and including the newline is header text.
      if (b == fnp_pkg::CHAR_LF) fp_in_hdr = 1'b0;
    end else if (b == fnp_pkg::CHAR_GT) begin
      flush_partial_byte();
      close_sequence_record();
      fp_hdr_count = fp_hdr_count + 1'b1;
      fp_in_hdr    = 1'b1;
    end else if (b >= fnp_pkg::CHAR_A && b <= fnp_pkg::CHAR_LAST) begin
      upper = b & 8'hDF;
      if (upper == fnp_pkg::CHAR_G)      code = 2'd1;
      else if (upper == fnp_pkg::CHAR_T) code = 2'd2;
      else if (upper == fnp_pkg::CHAR_C) code = 2'd3;
      else                               code = 2'd0;
      // The first base of a byte lands in the top two bits.
      case (fp_slot)
        2'd0:    fp_acc[7:6] = code;
        2'd1:    fp_acc[5:4] = code;
        2'd2:    fp_acc[3:2] = code;
        default: fp_acc[1:0] = code;
      endcase
      fp_seq_bases = fp_seq_bases + 1'b1;
      if (fp_slot == 2'd3) begin
        expected_results.push_back(make_result(fnp_pkg::RES_PACKED, fp_acc, '0, '0, '0));
        fp_acc       = '0;
        fp_slot      = '0;
        fp_seq_bytes = fp_seq_bytes + 1'b1;
      end else begin
        fp_slot = fp_slot + 1'b1;
      end
    end
    n_out = expected_results.size() - size_before;
    if (n_out > 0) begin
      expected_results[expected_results.size() - 1].last_result = 1'b1;
      last_out = expected_results[expected_results.size() - 1];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic bit results_differ(result_t want, result_t got);
    return got.kind !== want.kind || got.packed_byte !== want.packed_byte ||
           got.byte_count !== want.byte_count ||
           got.base_position !== want.base_position ||
           got.sequence_total !== want.sequence_total ||
           got.last_result !== want.last_result;
  endfunction

  // Only the first few failures are printed so a broken block cannot flood
  // the log; the rest are counted.
  function automatic void flag_error(string what, result_t want, result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
      $display("  expected kind=%0d byte=%02h count=%0d pos=%0d seqs=%0d last=%0b",
               want.kind, want.packed_byte, want.byte_count, want.base_position,
               want.sequence_total, want.last_result);
      $display("  actual   kind=%0d byte=%02h count=%0d pos=%0d seqs=%0d last=%0b",
               got.kind, got.packed_byte, got.byte_count, got.base_position,
               got.sequence_total, got.last_result);
    end
  endfunction

  // Every pop transaction is matched against the oldest expectation. The
  // ports are read right after the edge, before the block updates them.
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_n && pop && !empty) begin
      got.kind           = out_kind;
      got.packed_byte    = out_packed_byte;
      got.byte_count     = out_byte_count;
      got.base_position  = out_base_position;
      got.sequence_total = out_sequence_total;
      got.last_result    = out_last_result;
      if (expected_results.size() == 0) begin
        flag_error("result popped with nothing expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (results_differ(want, got)) flag_error("result mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // Before each result pop goes low for a random gap, unless the quiet flag is
  // set. A hold request stalls the output long enough that the block backs up
  // into its input. Pop stays high across back-to-back transactions rather
  // than being toggled in one step.
  initial begin : receiver
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offers one byte after a random gap and returns at the edge where the push
  // transaction completes; the predictor runs at that same edge.
  task automatic send_byte(input logic req, input logic [7:0] b,
                           output result_t last_pred, output int n_pred);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    in_req_type <= req;
    in_byte     <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_packing(req, b, last_pred, n_pred);
    sent_items++;
  endtask

  function automatic logic [7:0] random_base();
    case ($urandom_range(0, 19))
      0:       return 8'($urandom_range(fnp_pkg::CHAR_A, fnp_pkg::CHAR_LAST));
      1:       return "N";
      default: return base_alphabet[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin : stimulus
    result_t    last_pred;
    result_t    want;
    int         n_pred;
    int         pick;
    int         len;
    logic [7:0] hb;
    bit         hold_done;
    bit         pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    clear_packer_state();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Rows with a typed expectation also cross-check the
    // predictor; every row is checked against the block by the monitor.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(directed_rows[i].req, directed_rows[i].data, last_pred, n_pred);
      if (directed_rows[i].check) begin
        want = make_result(directed_rows[i].kind, directed_rows[i].packed_byte,
                           directed_rows[i].byte_count, directed_rows[i].base_position,
                           directed_rows[i].sequence_total);
        want.last_result = 1'b1;
        if (n_pred == 0 || results_differ(want, last_pred))
          flag_error($sformatf("directed row %0d", i), want, last_pred);
      end
    end

    // Random FASTA. Most of it is well-formed records: a header line, then
    // lines of bases. Noise bytes, headers that never see their newline and
    // stray ends of input are mixed in at lower rates.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (!hold_done && sent_items >= 120) begin
        // Stall the output while bases keep coming at full rate, so the
        // block fills up and holds full high.
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (BURST_BASES) send_byte(fnp_pkg::REQ_DATA, random_base(), last_pred, n_pred);
        tx_quiet  = 1'b0;
        hold_done = 1'b1;
      end
      if (!pause_done && sent_items >= 250) begin
        // Let the block drain completely before going on.
        push <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_byte(fnp_pkg::REQ_END, 8'($urandom_range(0, 255)), last_pred, n_pred);
      end else if (pick < 20) begin
        send_byte(fnp_pkg::REQ_DATA, fnp_pkg::CHAR_GT, last_pred, n_pred);
        len = $urandom_range(0, 8);
        repeat (len) begin
          // Header text may hold any byte but the newline, '>' included.
          hb = 8'($urandom_range(0, 255));
          if (hb == fnp_pkg::CHAR_LF) hb = fnp_pkg::CHAR_GT;
          send_byte(fnp_pkg::REQ_DATA, hb, last_pred, n_pred);
        end
        if ($urandom_range(0, 7) != 0)
          send_byte(fnp_pkg::REQ_DATA, fnp_pkg::CHAR_LF, last_pred, n_pred);
      end else if (pick < 28) begin
        send_byte(fnp_pkg::REQ_DATA, 8'($urandom_range(0, 255)), last_pred, n_pred);
      end else begin
        len = $urandom_range(1, 24);
        repeat (len) send_byte(fnp_pkg::REQ_DATA, random_base(), last_pred, n_pred);
        send_byte(fnp_pkg::REQ_DATA, fnp_pkg::CHAR_LF, last_pred, n_pred);
      end
      if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
    end

    // Close the last stream so any partial byte comes out, then drain.
    send_byte(fnp_pkg::REQ_END, 8'h00, last_pred, n_pred);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** fasta_nucleotide_packer: PASSED **");
    end else begin
      $display("** fasta_nucleotide_packer: FAILED **");
    end
    $finish;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[%0t] timeout with %0d results outstanding", $time,
             expected_results.size());
    $display("** fasta_nucleotide_packer: FAILED **");
    $finish;
  end

endmodule
